// ----- hw/rtl/mne_pkg.sv -----
// shared types, constants and codes of the mesh normal engine
package mne_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int IDX_W        = 10;
  localparam int POS_W        = 24;
  localparam int SUM_W        = 32;
  localparam int NRM_W        = 16;
  localparam int CRS_W        = 52;
  localparam int MAG_W        = CRS_W - 1;
  localparam int Q_W          = 30;
  localparam int SQ_W         = 62;
  localparam int ROOT_W       = 64;
  localparam int LEN_W        = 31;
  localparam int DIV_W        = Q_W + 15;
  localparam int QUO_W        = 15;
  localparam int CNT_W        = 6;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_FACE  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic {
    KIND_FACE   = 1'b0,
    KIND_VERTEX = 1'b1
  } kind_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] coord_x;
    logic signed [POS_W-1:0] coord_y;
    logic signed [POS_W-1:0] coord_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
  } in_item_t;

  typedef struct packed {
    logic                    kind;
    logic [IDX_W-1:0]        result_index;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    degenerate;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_DECODE, ST_LOAD, ST_RD_A, ST_RD_B, ST_RD_C, ST_RD_W,
    ST_EDGE, ST_MUL, ST_ABS, ST_SHIFT, ST_SQ, ST_ROOT, ST_DIV, ST_EMIT,
    ST_SRD, ST_SCAP, ST_SUM_RD, ST_SUM_WR
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_IDLE, OP_LOAD, OP_RD_A, OP_RD_B, OP_RD_C, OP_RD_W,
    OP_EDGE, OP_MUL, OP_ABS, OP_SHIFT, OP_SQ, OP_ROOT, OP_DIV, OP_EMIT,
    OP_SRD, OP_SCAP, OP_SUM_RD, OP_SUM_WR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic cnt_clr;
    logic cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic             in_valid;
    logic [1:0]       action;
    logic [CNT_W-1:0] cnt;
    logic             big;
    logic             zero_sq;
    logic             clr_last;
    logic             out_free;
  } status_t;

endpackage

// ----- hw/rtl/mne_if.sv -----
// input and result channels of the mesh normal engine
interface mne_in_if (input logic clk);
  logic              valid;
  logic              ready;
  mne_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mne_out_if (input logic clk);
  logic               valid;
  logic               ready;
  mne_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/mesh_normal_engine.sv -----
// top level of the mesh normal engine: sequencer plus datapath
//
//   channel | dir | beat
//   req     | in  | action, vertex_index, coord_x/y/z, corner_a/b/c
//   rsp     | out | kind, result_index, normal_x/y/z, degenerate
//
// one item at a time; a clear writes one sum entry a cycle
// a face or read runs the 32-step root and three 16-step divisions, plus one scaling
// shift per magnitude bit above 30; a zero-length vector skips root and division
// after reset a clearing pass zeroes the sum store before req opens
// a finished result waits in the output register while the next beat is taken;
// a new result stalls only until that register is free
module mesh_normal_engine (
  input logic       clk,
  input logic       rst,
  mne_in_if.sink    req,
  mne_out_if.source rsp
);
  import mne_pkg::*;

  cmd_t    cmd;
  status_t status;

  mne_ctl u_ctl (
    .clk(clk), .rst(rst), .status(status), .cmd(cmd)
  );

  mne_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .req(req), .rsp(rsp)
  );
endmodule

// ----- hw/rtl/mne_ram.sv -----
// generic single-port ram with registered read
module mne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- hw/rtl/mne_ctl.sv -----
// sequencer of the mesh normal engine
module mne_ctl (
  input  logic             clk,
  input  logic             rst,
  input  mne_pkg::status_t status,
  output mne_pkg::cmd_t    cmd
);
  import mne_pkg::*;

  state_t state, state_next;

  // state register, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd.op      = OP_NONE;
    cmd.cnt_clr = 1'b0;
    cmd.cnt_inc = 1'b0;
    unique case (state)
      ST_CLR: begin
        cmd.op = OP_CLR;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.op = OP_IDLE;
        if (status.in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.cnt_clr = 1'b1;
        unique case (action_t'(status.action))
          ACT_LOAD:  state_next = ST_LOAD;
          ACT_FACE:  state_next = ST_RD_A;
          ACT_CLEAR: state_next = ST_CLR;
          ACT_READ:  state_next = ST_SRD;
        endcase
      end
      ST_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = ST_IDLE;
      end
      ST_RD_A: begin
        cmd.op     = OP_RD_A;
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.op     = OP_RD_B;
        state_next = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.op     = OP_RD_C;
        state_next = ST_RD_W;
      end
      ST_RD_W: begin
        cmd.op     = OP_RD_W;
        state_next = ST_EDGE;
      end
      ST_EDGE: begin
        cmd.op      = OP_EDGE;
        cmd.cnt_clr = 1'b1;
        state_next  = ST_MUL;
      end
      ST_MUL: begin
        cmd.op      = OP_MUL;
        cmd.cnt_inc = 1'b1;
        if (status.cnt == CNT_W'(6)) state_next = ST_ABS;
      end
      ST_ABS: begin
        cmd.op     = OP_ABS;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.op      = OP_SHIFT;
        cmd.cnt_clr = 1'b1;
        if (!status.big) state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.op = OP_SQ;
        if (status.cnt == CNT_W'(3)) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_ROOT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_ROOT: begin
        cmd.op = OP_ROOT;
        if (status.zero_sq) begin
          state_next = ST_EMIT;
        end else if (status.cnt == CNT_W'(31)) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_DIV;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.op      = OP_DIV;
        cmd.cnt_inc = 1'b1;
        if (status.cnt == CNT_W'(47)) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.op      = OP_EMIT;
        cmd.cnt_clr = 1'b1;
        if (status.out_free) begin
          state_next = (action_t'(status.action) == ACT_FACE) ? ST_SUM_RD : ST_IDLE;
        end
      end
      ST_SRD: begin
        cmd.op     = OP_SRD;
        state_next = ST_SCAP;
      end
      ST_SCAP: begin
        cmd.op     = OP_SCAP;
        state_next = ST_ABS;
      end
      ST_SUM_RD: begin
        cmd.op     = OP_SUM_RD;
        state_next = ST_SUM_WR;
      end
      ST_SUM_WR: begin
        cmd.op = OP_SUM_WR;
        if (status.cnt == CNT_W'(2)) begin
          state_next = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = ST_SUM_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ----- hw/rtl/mne_dp.sv -----
// datapath: stores, cross product, normalizer and sum update
module mne_dp (
  input  logic             clk,
  input  logic             rst,
  input  mne_pkg::cmd_t    cmd,
  output mne_pkg::status_t status,
  mne_in_if.sink           req,
  mne_out_if.source        rsp
);
  import mne_pkg::*;

  in_item_t                item;
  logic [3*POS_W-1:0]      pos_wdata, pos_rdata, pa, pb;
  logic [ADDR_W-1:0]       pos_addr, sum_addr, clr_addr;
  logic                    pos_we, sum_we;
  logic [3*SUM_W-1:0]      sum_wdata, sum_rdata;
  logic [IDX_W-1:0]        corner [3];
  logic signed [POS_W:0]   u [3];
  logic signed [POS_W:0]   v [3];
  logic signed [POS_W:0]   ma, mb;
  logic signed [2*POS_W+1:0] prod;
  logic signed [CRS_W-1:0] cr [3];
  logic [MAG_W-1:0]        m [3];
  logic                    neg [3];
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        km1;
  logic [2*Q_W-1:0]        sq;
  logic [SQ_W-1:0]         ssum;
  logic [ROOT_W-1:0]       rs, r, s_cur, r_cur, bitv, trial;
  logic [5:0]              shamt;
  logic [LEN_W-1:0]        len;
  logic [1:0]              comp;
  logic [3:0]              step, k;
  logic [DIV_W-1:0]        rem, num, dsh, rem_next;
  logic [QUO_W-1:0]        quot, quot_next;
  logic                    ge;
  logic signed [NRM_W-1:0] n [3];
  logic signed [NRM_W-1:0] n_eff [3];
  logic                    out_valid;
  out_item_t               out_data;

  // position and sum stores
  mne_ram #(.WIDTH(3*POS_W), .DEPTH(MAX_VERTICES)) u_pos (
    .clk(clk), .we(pos_we), .addr(pos_addr), .wdata(pos_wdata), .rdata(pos_rdata)
  );
  mne_ram #(.WIDTH(3*SUM_W), .DEPTH(MAX_VERTICES)) u_sum (
    .clk(clk), .we(sum_we), .addr(sum_addr), .wdata(sum_wdata), .rdata(sum_rdata)
  );

  assign corner[0] = item.corner_a;
  assign corner[1] = item.corner_b;
  assign corner[2] = item.corner_c;

  // position store port
  always_comb begin
    pos_we    = (cmd.op == OP_LOAD);
    pos_wdata = {item.coord_x, item.coord_y, item.coord_z};
    unique case (cmd.op)
      OP_RD_A: pos_addr = ADDR_W'(item.corner_a);
      OP_RD_B: pos_addr = ADDR_W'(item.corner_b);
      OP_RD_C, OP_RD_W: pos_addr = ADDR_W'(item.corner_c);
      default: pos_addr = ADDR_W'(item.vertex_index);
    endcase
  end

  // saturating add of the face normal into the sum word
  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] s,
                                              logic signed [NRM_W-1:0] d);
    logic signed [SUM_W:0] t;
    t = $signed({s[SUM_W-1], s}) + (SUM_W+1)'(d);
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

  for (genvar i = 0; i < 3; i++) begin : g_neff
    assign n_eff[i] = (ssum == '0) ? '0 : n[i];
  end

  // sum store port
  always_comb begin
    sum_we    = (cmd.op == OP_CLR) || (cmd.op == OP_SUM_WR);
    sum_wdata = '0;
    unique case (cmd.op)
      OP_CLR:    sum_addr = clr_addr;
      OP_SRD:    sum_addr = ADDR_W'(item.vertex_index);
      default:   sum_addr = ADDR_W'(corner[cnt[1:0]]);
    endcase
    if (cmd.op == OP_SUM_WR) begin
      sum_wdata = {sat_add(sum_rdata[3*SUM_W-1:2*SUM_W], n_eff[0]),
                   sat_add(sum_rdata[2*SUM_W-1:SUM_W], n_eff[1]),
                   sat_add(sum_rdata[SUM_W-1:0], n_eff[2])};
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.op == OP_CLR) begin
      clr_addr <= (clr_addr == ADDR_W'(MAX_VERTICES - 1)) ? '0 : clr_addr + 1'b1;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  // input beat capture
  assign req.ready = (cmd.op == OP_IDLE);
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) item <= req.payload;
  end

  // corner positions and edges
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RD_B) pa <= pos_rdata;
    if (cmd.op == OP_RD_C) pb <= pos_rdata;
    if (cmd.op == OP_EDGE) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= $signed(pb[(2-i)*POS_W +: POS_W]) - $signed(pa[(2-i)*POS_W +: POS_W]);
        v[i] <= $signed(pos_rdata[(2-i)*POS_W +: POS_W])
              - $signed(pb[(2-i)*POS_W +: POS_W]);
      end
    end
  end

  // cross product operands, one product a cycle
  always_comb begin
    km1 = cnt - 1'b1;
    unique case (cnt[2:0])
      3'd0:    begin ma = u[1]; mb = v[2]; end
      3'd1:    begin ma = u[2]; mb = v[1]; end
      3'd2:    begin ma = u[2]; mb = v[0]; end
      3'd3:    begin ma = u[0]; mb = v[2]; end
      3'd4:    begin ma = u[0]; mb = v[1]; end
      default: begin ma = u[1]; mb = v[0]; end
    endcase
  end

  // cross product accumulate, abs and scaling shift
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_MUL: begin
        prod <= ma * mb;
        if (cnt != '0) begin
          if (!km1[0]) cr[km1[2:1]] <= CRS_W'(prod);
          else         cr[km1[2:1]] <= cr[km1[2:1]] - CRS_W'(prod);
        end
      end
      OP_SCAP: begin
        cr[0] <= CRS_W'($signed(sum_rdata[3*SUM_W-1:2*SUM_W]));
        cr[1] <= CRS_W'($signed(sum_rdata[2*SUM_W-1:SUM_W]));
        cr[2] <= CRS_W'($signed(sum_rdata[SUM_W-1:0]));
      end
      OP_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= cr[i][CRS_W-1];
          m[i]   <= cr[i][CRS_W-1] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
        end
      end
      OP_SHIFT: begin
        if (status.big) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
        end
      end
      default: ;
    endcase
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQ) begin
      if (cnt < CNT_W'(3)) sq <= m[cnt[1:0]][Q_W-1:0] * m[cnt[1:0]][Q_W-1:0];
      if (cnt == '0) ssum <= '0;
      else           ssum <= ssum + SQ_W'(sq);
    end
  end

  // square root, digit by digit, from the most significant result bit down
  always_comb begin
    s_cur = (cnt == '0) ? ROOT_W'(ssum) : rs;
    r_cur = (cnt == '0) ? '0 : r;
    shamt = 6'd62 - {cnt[4:0], 1'b0};
    bitv  = ROOT_W'(1) << shamt;
    trial = r_cur + bitv;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ROOT) begin
      if (s_cur >= trial) begin
        rs <= s_cur - trial;
        r  <= (r_cur >> 1) + bitv;
      end else begin
        rs <= s_cur;
        r  <= r_cur >> 1;
      end
    end
  end
  assign len = r[LEN_W-1:0];

  // restoring division, one quotient bit a step
  always_comb begin
    comp      = cnt[5:4];
    step      = cnt[3:0];
    k         = 4'd15 - step;
    num       = {1'b0, m[comp][Q_W-1:0], 14'b0} + DIV_W'(len >> 1);
    dsh       = DIV_W'(len) << k;
    ge        = (rem >= dsh);
    rem_next  = ge ? rem - dsh : rem;
    quot_next = ge ? quot | (QUO_W'(1) << k) : quot;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV) begin
      if (step == '0) begin
        rem  <= num;
        quot <= '0;
      end else begin
        rem  <= rem_next;
        quot <= quot_next;
        if (step == 4'd15) begin
          n[comp] <= neg[comp] ? -NRM_W'(quot_next) : NRM_W'(quot_next);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT && status.out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT && status.out_free) begin
      out_data.kind         <= (action_t'(item.action) == ACT_READ) ? KIND_VERTEX : KIND_FACE;
      out_data.result_index <= (action_t'(item.action) == ACT_READ) ? item.vertex_index
                                                                     : item.corner_a;
      out_data.normal_x     <= n_eff[0];
      out_data.normal_y     <= n_eff[1];
      out_data.normal_z     <= n_eff[2];
      out_data.degenerate   <= (ssum == '0);
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  // status back to the sequencer
  always_comb begin
    status.in_valid = req.valid;
    status.action   = item.action;
    status.cnt      = cnt;
    status.big      = (m[0][MAG_W-1:Q_W] != '0) || (m[1][MAG_W-1:Q_W] != '0)
                   || (m[2][MAG_W-1:Q_W] != '0);
    status.zero_sq  = (ssum == '0);
    status.clr_last = (clr_addr == ADDR_W'(MAX_VERTICES - 1));
    status.out_free = !out_valid || rsp.ready;
  end

  // squaring starts only on scaled magnitudes
  a_scaled: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SQ && cnt == '0) |-> !status.big)
    else $error("squaring before scaling finished");

  // a degenerate result carries the zero vector
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate) |->
      (out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0))
    else $error("degenerate result with nonzero normal");

  // components stay within unit range
  a_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.normal_x <= 16384 && out_data.normal_x >= -16384
                && out_data.normal_y <= 16384 && out_data.normal_y >= -16384
                && out_data.normal_z <= 16384 && out_data.normal_z >= -16384))
    else $error("normal component out of unit range");
endmodule
